// ===== rtl/s256_pkg.sv =====
// s256_pkg: shared types, constants and round functions for the sha-256 hasher
// no dependencies
package s256_pkg;

  localparam logic [0:0] OP_ABSORB = 1'b0;
  localparam logic [0:0] OP_FINISH = 1'b1;

  localparam int QUEUE_DEPTH = 4;

  // one queued request from front to back
  typedef struct packed {
    logic [0:0] opcode;
    logic [7:0] byte_value;
  } s256_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } s256_state_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
  endfunction

endpackage

// ===== rtl/s256_queue.sv =====
// s256_queue: short request queue between the front and the compression engine
// depends on s256_pkg
module s256_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  s256_pkg::s256_req_t  push_req,
  output logic                 full,
  input  logic                 pop,
  output s256_pkg::s256_req_t  pop_req,
  output logic                 not_empty
);
  import s256_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  s256_req_t       slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     count_r;

  assign full      = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_req   = slot_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/s256_engine.sv =====
// s256_engine: block buffer, padding, 64-round compression and digest output
// depends on s256_pkg
module s256_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_valid,
  input  s256_pkg::s256_req_t  req,
  output logic                 req_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_digest_word,
  output logic                 out_last_word
);
  import s256_pkg::*;

  s256_state_t  state_r, state_nxt;
  logic [31:0]  chain_r [8];
  logic [31:0]  work_r  [8];
  logic [31:0]  sched_r [16];      // sliding 16-word message schedule
  logic [5:0]   fill_r;
  logic [63:0]  bits_r;
  logic [5:0]   round_r;
  logic         final_r;           // block being compressed ends the message
  logic         extra_r;           // length must go in a second padding block
  logic [2:0]   emit_r;

  logic         absorb_go, finish_go, emit_go;
  logic [31:0]  w_cur, w_new, t1, t2;

  assign absorb_go = (state_r == ST_IDLE) && req_valid && (req.opcode == OP_ABSORB);
  assign finish_go = (state_r == ST_IDLE) && req_valid && (req.opcode == OP_FINISH);
  assign req_pop   = absorb_go || finish_go;
  assign emit_go   = (state_r == ST_EMIT) && !out_stall;

  assign out_valid       = (state_r == ST_EMIT);
  assign out_digest_word = chain_r[emit_r];
  assign out_last_word   = (emit_r == 3'd7);

  // round datapath
  always_comb begin
    w_cur = sched_r[0];
    w_new = ssig1(sched_r[14]) + sched_r[9] + ssig0(sched_r[1]) + sched_r[0];
    t1 = work_r[7] + bsig1(work_r[4]) +
         ((work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6])) +
         ROUND_K[round_r] + w_cur;
    t2 = bsig0(work_r[0]) +
         ((work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (absorb_go && fill_r == 6'd63)       state_nxt = ST_ROUND;
        else if (finish_go && fill_r > 6'd55)   state_nxt = ST_ROUND;
        else if (finish_go)                     state_nxt = ST_PAD;
      end
      ST_PAD:   state_nxt = ST_ROUND;
      ST_ROUND: if (round_r == 6'd63) state_nxt = ST_ADD;
      ST_ADD: begin
        if (!final_r)     state_nxt = ST_IDLE;
        else if (extra_r) state_nxt = ST_PAD;
        else              state_nxt = ST_EMIT;
      end
      ST_EMIT:  if (emit_go && emit_r == 3'd7) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // control and chaining state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      bits_r  <= '0;
      round_r <= '0;
      final_r <= 1'b0;
      extra_r <= 1'b0;
      emit_r  <= '0;
      for (int i = 0; i < 8; i++) chain_r[i] <= INIT_HASH[i];
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          round_r <= '0;
          if (absorb_go) begin
            fill_r <= fill_r + 1'b1;
            bits_r <= bits_r + 64'd8;
            final_r <= 1'b0;
          end
          if (finish_go) begin
            final_r <= 1'b1;
            extra_r <= (fill_r > 6'd55);
          end
        end
        ST_PAD: begin
          round_r <= '0;
        end
        ST_ROUND: round_r <= round_r + 1'b1;
        ST_ADD: begin
          for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + work_r[i];
          fill_r  <= '0;
          emit_r  <= '0;
        end
        ST_EMIT: begin
          if (emit_go) begin
            emit_r <= emit_r + 1'b1;
            if (emit_r == 3'd7) begin
              for (int i = 0; i < 8; i++) chain_r[i] <= INIT_HASH[i];
              bits_r  <= '0;
              final_r <= 1'b0;
              extra_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
      if (state_r == ST_PAD) extra_r <= 1'b0;
    end
  end

  // block buffer, schedule and working variables
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        for (int i = 0; i < 8; i++) work_r[i] <= chain_r[i];
        if (absorb_go) begin
          sched_r[fill_r[5:2]][8*(3-int'(fill_r[1:0])) +: 8] <= req.byte_value;
        end
        if (finish_go) begin
          // 0x80 marker then zero the rest of the block
          for (int j = 0; j < 64; j++) begin
            if (6'(j) == fill_r)
              sched_r[j/4][8*(3-(j%4)) +: 8] <= 8'h80;
            else if (6'(j) > fill_r)
              sched_r[j/4][8*(3-(j%4)) +: 8] <= 8'h00;
          end
        end
      end
      ST_PAD: begin
        // length words; whole block zeroed first when this is the extra block
        if (extra_r) begin
          for (int i = 0; i < 14; i++) sched_r[i] <= '0;
        end
        sched_r[14] <= bits_r[63:32];
        sched_r[15] <= bits_r[31:0];
        for (int i = 0; i < 8; i++) work_r[i] <= chain_r[i];
      end
      ST_ROUND: begin
        for (int i = 0; i < 15; i++) sched_r[i] <= sched_r[i+1];
        sched_r[15] <= w_new;
        work_r[7] <= work_r[6];
        work_r[6] <= work_r[5];
        work_r[5] <= work_r[4];
        work_r[4] <= work_r[3] + t1;
        work_r[3] <= work_r[2];
        work_r[2] <= work_r[1];
        work_r[1] <= work_r[0];
        work_r[0] <= t1 + t2;
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) work_r[i] <= chain_r[i] + work_r[i];
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/sha256_byte_stream_hasher.sv =====
// sha256_byte_stream_hasher: top level, request queue feeding the compression engine
// depends on s256_pkg, s256_queue, s256_engine
//
// usage
//   input channel: in_valid/in_stall with in_opcode and in_byte_value.
//   opcode absorb adds one message byte; opcode finish pads the message and
//   produces the digest as eight 32-bit big-endian words on the output
//   channel (out_valid/out_stall), word 0 first, out_last_word on word 7.
//   requests enter a four-entry queue, so the source keeps going while
//   the engine compresses or while the digest waits to be taken.
// operation
//   the engine takes an absorb whenever it is idle; the 64th byte of a block
//   starts 64 rounds, one per cycle, followed by the chaining add.
//   a finish pads and compresses one or two blocks before the first digest word, then one
//   word per cycle while out_stall is low. the single round unit sets the rate.
// reset
//   rst_n low clears the queue and loads the initial hash values.
// stall
//   while out_stall is high the current word holds; the queue fills and
//   in_stall rises when it is full.
module sha256_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [0:0]  in_opcode,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic        out_last_word
);
  import s256_pkg::*;

  s256_req_t in_req, q_req;
  logic      q_full, q_nempty, q_pop, push;

  assign in_req.opcode     = in_opcode;
  assign in_req.byte_value = in_byte_value;
  assign in_stall          = q_full;
  assign push              = in_valid && !q_full;

  // front: request queue
  s256_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_req(in_req), .full(q_full),
    .pop(q_pop), .pop_req(q_req), .not_empty(q_nempty)
  );

  // back: compression and digest output
  s256_engine u_engine (
    .clk(clk), .rst_n(rst_n),
    .req_valid(q_nempty), .req(q_req), .req_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_last_word(out_last_word)
  );

endmodule

// ===== rtl/s256_checker.sv =====
// s256_checker: port-level assertions for the hasher
// depends on sha256_byte_stream_hasher ports only
module s256_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic        out_last_word
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word)
      && $stable(out_last_word))
    else $error("stalled digest word changed");

  // digest words follow each other back to back unless stalled
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=> out_valid)
    else $error("digest burst broken");

  // nothing comes out and the queue is open right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output valid or input stalled after reset");

  // last word ends the burst
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_word |=> !out_valid)
    else $error("output after last word");

endmodule

bind sha256_byte_stream_hasher s256_checker u_s256_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_digest_word(out_digest_word), .out_last_word(out_last_word)
);

// ===== tb/sha256_digest_checker.sv =====
// sha256_digest_checker: watches both channels of the sha-256 hasher, computes
// expected digests from accepted requests and compares every output word
// depends on s256_pkg (opcode names)
`timescale 1ns / 1ps

module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [0:0]  in_opcode,
  input  logic [7:0]  in_byte_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_digest_word,
  input  logic        out_last_word,
  output int          fail_count,
  output int          pending_words,
  output int          digests_seen
);
  import s256_pkg::*;

  typedef struct {
    logic [31:0] word;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  logic [5:0]  block_fill;
  logic [63:0] bit_length;
  digest_word_t digest_q [$];

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of msg_block into hash_state
  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
           + w[t-7] + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic restart();
    for (int i = 0; i < 8; i++) hash_state[i] = IV_TAB[i];
    block_fill = '0;
    bit_length = '0;
  endtask

  // apply one accepted request to the predicted hash
  task automatic apply_request(logic [0:0] op, logic [7:0] data);
    int i;
    digest_word_t dw;
    if (op == OP_ABSORB) begin
      msg_block[block_fill] = data;
      bit_length += 64'd8;
      block_fill += 6'd1;
      if (block_fill == 0) compress();
    end else begin
      i = block_fill;
      msg_block[i++] = 8'h80;
      if (i > 56) begin
        while (i < 64) msg_block[i++] = 8'h00;
        compress();
        i = 0;
      end
      while (i < 56) msg_block[i++] = 8'h00;
      for (int j = 0; j < 8; j++) msg_block[56+j] = bit_length[63-8*j -: 8];
      compress();
      for (int j = 0; j < 8; j++) begin
        dw.word = hash_state[j];
        dw.last = (j == 7);
        digest_q.push_back(dw);
      end
      restart();
    end
  endtask

  initial begin
    fail_count = 0;
    digests_seen = 0;
    pending_words = 0;
    restart();
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
  end

  // watch both channels at each edge
  always @(posedge clk) begin
    digest_word_t exp_w;
    if (rst_n) begin
      if (in_valid && !in_stall) apply_request(in_opcode, in_byte_value);
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h", out_digest_word);
          fail_count++;
        end else begin
          exp_w = digest_q.pop_front();
          if (out_digest_word !== exp_w.word) begin
            $error("digest_word expected %h actual %h", exp_w.word, out_digest_word);
            fail_count++;
          end
          if (out_last_word !== exp_w.last) begin
            $error("last_word expected %0d actual %0d", exp_w.last, out_last_word);
            fail_count++;
          end
          if (exp_w.last) digests_seen++;
        end
      end
    end
    pending_words = digest_q.size();
  end
endmodule

// ===== tb/sha256_byte_stream_hasher_tb.sv =====
// sha256_byte_stream_hasher_tb: drives byte and finish requests into the hasher
// with random idling; depends on s256_pkg, the hasher rtl and sha256_digest_checker
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_tb;
  import s256_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [0:0]  in_opcode = OP_ABSORB;
  logic [7:0]  in_byte_value = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] out_digest_word;
  logic        out_last_word;
  int          fail_count, pending_words, digests_seen;
  int          request_count = 0;
  bit          calm = 0;

  always #4 clk = ~clk;

  sha256_byte_stream_hasher uut (.*);

  sha256_digest_checker checker_i (.*);

  // send one request, with an optional random gap before it
  task automatic send_request(logic [0:0] op, logic [7:0] data);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_opcode <= op;
    in_byte_value <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    request_count++;
  endtask

  task automatic send_message(int len, int mode);
    for (int i = 0; i < len; i++)
      case (mode)
        0: send_request(OP_ABSORB, 8'($urandom_range(0, 255)));
        1: send_request(OP_ABSORB, 8'h00);
        default: send_request(OP_ABSORB, 8'hff);
      endcase
    send_request(OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // random output stalls in bursts
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 11);
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
    end
  end

  initial begin
    int len;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: empty messages, byte extremes and a short random message
    send_message(0, 0);
    send_message(1, 1);
    send_message(1, 2);
    send_message(3, 0);
    send_request(OP_FINISH, 8'hff);
    // random messages, lengths around the padding edges most often
    while (request_count < 470) begin
      case ($urandom_range(0, 5))
        0: len = $urandom_range(0, 8);
        1: len = $urandom_range(54, 57);
        2: len = $urandom_range(63, 65);
        3: len = $urandom_range(118, 121);
        default: len = $urandom_range(0, 40);
      endcase
      // keep the total close to the request budget
      if (len > 469 - request_count) len = 469 - request_count;
      if (request_count > 400) calm = 1;
      send_message(len, $urandom_range(0, 9) == 0 ? 2 : 0);
    end
    in_valid <= 0;
    while (pending_words != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("sent %0d requests, checked %0d digests", request_count, digests_seen);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
